### src/tns_pkg.sv
// ----------------------------------------------------------------------------
// tns_pkg
// shared types and constants for the top-n score selector
// ----------------------------------------------------------------------------
package tns_pkg;

    localparam int MaxTopDef     = 8;
    localparam int MaxClassesDef = 1024;

    localparam int ScoreW      = 32;
    localparam int ClassIndexW = 10;
    localparam int TopCountW   = 4;
    localparam int DataW       = 32;
    localparam int AddrW       = 2;

    localparam logic [TopCountW-1:0] TopCountRst = TopCountW'(5);

    typedef enum logic [AddrW-1:0] {
        REG_TOP_COUNT = 2'b00
    } t_reg_addr;

    typedef enum logic [1:0] {
        S_COLLECT = 2'b01,
        S_DRAIN   = 2'b10
    } t_state;

    typedef struct packed {
        logic                     valid;
        logic signed [ScoreW-1:0] score;
        logic [ClassIndexW-1:0]   index;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

### src/tns_if.sv
// ----------------------------------------------------------------------------
// tns_if
// valid/ready channels for score words in and class words out
// ----------------------------------------------------------------------------
interface tns_in_if;
    import tns_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ScoreW-1:0] score;
    logic                     last_score;

    modport source (output valid, output score, output last_score, input ready);
    modport sink   (input valid, input score, input last_score, output ready);
endinterface

interface tns_out_if;
    import tns_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [ClassIndexW-1:0]   class_index;
    logic signed [ScoreW-1:0] class_score;
    logic                     last_result;

    modport source (output valid, output class_index, output class_score,
                    output last_result, input ready);
    modport sink   (input valid, input class_index, input class_score,
                    input last_result, output ready);
endinterface

### src/top_n_score_select.sv
// ----------------------------------------------------------------------------
// top_n_score_select
// streaming top-n class selection over a vector of scores
// ----------------------------------------------------------------------------
// scores arrive at most one word per cycle on i_in, numbered by arrival from 0;
// the word flagged last_score closes the vector. a chain of MaxTop cells keeps
// the best scores sorted, highest first, equal scores in arrival order; each
// word is placed by a compare in every cell and a shift of the lower slots, so
// i_in takes one score per cycle while a vector streams in. scores past
// MaxClasses positions are dropped, the flag still ends the vector. in the
// cycle after the last word is taken, o_out shows the best class; the chain
// moves up one slot per word taken, so o_out gives the n results in order,
// n = top_count (0 read as 1, capped at MaxTop) cut to scores received.
// i_in.ready stays low from the last word until the final result is taken;
// a stalled receiver simply holds the chain. top_count sits at byte address
// 0 of the apb port, reset value 5. reset empties the chain, clears the
// position count and makes the block ready for a new vector.
// ----------------------------------------------------------------------------
module top_n_score_select #(
    parameter int MaxTop     = tns_pkg::MaxTopDef,
    parameter int MaxClasses = tns_pkg::MaxClassesDef
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tns_in_if.sink                     i_in,
    tns_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tns_pkg::AddrW-1:0]  paddr,
    input  logic [tns_pkg::DataW-1:0]  pwdata,
    output logic [tns_pkg::DataW-1:0]  prdata,
    output logic                       pready
);
    import tns_pkg::*;

    localparam int CntW = $clog2(MaxTop + 1);
    localparam int PosW = $clog2(MaxClasses + 1);

    t_state                 r_state;
    t_state                 n_state;
    logic [TopCountW-1:0]   r_top;
    logic [PosW-1:0]        r_pos;
    logic [PosW-1:0]        n_pos;
    logic [CntW-1:0]        r_fill;
    logic [CntW-1:0]        n_fill;
    logic [CntW-1:0]        r_left;
    logic [CntW-1:0]        n_left;

    logic                   w_in_acc;
    logic                   w_out_acc;
    logic                   w_in_range;
    logic [CntW-1:0]        w_fill_next;
    logic [CntW-1:0]        w_req;
    logic [CntW-1:0]        w_n;
    logic [PosW+ClassIndexW-1:0] w_pos_ext;
    t_entry                 w_new;
    t_cell_ctrl             w_ctrl;
    t_entry                 w_entry [MaxTop];
    logic                   w_flag  [MaxTop];

    // config port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= TopCountRst;
        end else if (psel && penable && pwrite && (paddr == REG_TOP_COUNT)) begin
            r_top <= pwdata[TopCountW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_TOP_COUNT) begin
            prdata = {{(DataW-TopCountW){1'b0}}, r_top};
        end
    end

    // handshakes
    assign i_in.ready = (r_state == S_COLLECT);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign o_out.valid = (r_state == S_DRAIN);
    assign w_out_acc  = o_out.valid && o_out.ready;

    assign o_out.class_index = w_entry[0].index;
    assign o_out.class_score = w_entry[0].score;
    assign o_out.last_result = (r_left == CntW'(1));

    // new word for the chain
    assign w_in_range = (r_pos < PosW'(MaxClasses));
    assign w_pos_ext  = {{ClassIndexW{1'b0}}, r_pos};

    always_comb begin
        w_new.valid = 1'b1;
        w_new.score = i_in.score;
        w_new.index = w_pos_ext[ClassIndexW-1:0];
    end

    always_comb begin
        w_ctrl.insert = w_in_acc && w_in_range;
        w_ctrl.shift  = w_out_acc && (r_left != CntW'(1));
        w_ctrl.clear  = w_out_acc && (r_left == CntW'(1));
    end

    // insertion chain
    for (genvar k = 0; k < MaxTop; k++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_flag;

        if (k == 0) begin : g_head
            assign w_left      = '0;
            assign w_left_flag = 1'b0;
        end else begin : g_body
            assign w_left      = w_entry[k-1];
            assign w_left_flag = w_flag[k-1];
        end

        if (k == MaxTop - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_entry[k+1];
        end

        tns_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_new       (w_new),
            .i_left      (w_left),
            .i_right     (w_right),
            .i_left_flag (w_left_flag),
            .o_flag      (w_flag[k]),
            .o_entry     (w_entry[k])
        );
    end

    // result count
    always_comb begin
        w_fill_next = r_fill;
        if (w_ctrl.insert && w_flag[MaxTop-1] && (r_fill < CntW'(MaxTop))) begin
            w_fill_next = r_fill + CntW'(1);
        end
    end

    always_comb begin
        if (r_top == '0) begin
            w_req = CntW'(1);
        end else if (32'(r_top) > 32'(MaxTop)) begin
            w_req = CntW'(MaxTop);
        end else begin
            w_req = CntW'(r_top);
        end
        w_n = (w_req > w_fill_next) ? w_fill_next : w_req;
    end

    // control
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_fill  = r_fill;
        n_left  = r_left;
        case (r_state)
            S_COLLECT: begin
                if (w_in_acc) begin
                    n_fill = w_fill_next;
                    if (w_in_range) begin
                        n_pos = r_pos + PosW'(1);
                    end
                    if (i_in.last_score) begin
                        n_pos  = '0;
                        n_fill = '0;
                        n_left = w_n;
                        if (w_n != '0) begin
                            n_state = S_DRAIN;
                        end
                    end
                end
            end
            S_DRAIN: begin
                if (w_out_acc) begin
                    n_left = r_left - CntW'(1);
                    if (r_left == CntW'(1)) begin
                        n_state = S_COLLECT;
                    end
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_pos   <= '0;
            r_fill  <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_fill  <= n_fill;
            r_left  <= n_left;
        end
    end

    // checks
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> w_entry[0].valid)
        else $error("result shown from an empty slot");

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_left != '0))
        else $error("drain with no results left");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CntW'(MaxTop))
        else $error("fill count past chain length");

    a_back_to_collect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out.last_result) |=> (i_in.ready && !w_entry[0].valid))
        else $error("chain not emptied after final result");

endmodule

### src/tns_cell.sv
// ----------------------------------------------------------------------------
// tns_cell
// one slot of the sorted insertion chain, holds a score and its class index
// ----------------------------------------------------------------------------
module tns_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tns_pkg::t_cell_ctrl i_ctrl,
    input  tns_pkg::t_entry     i_new,
    input  tns_pkg::t_entry     i_left,
    input  tns_pkg::t_entry     i_right,
    input  logic                i_left_flag,
    output logic                o_flag,
    output tns_pkg::t_entry     o_entry
);
    import tns_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // new word belongs at or before this slot
    assign o_flag = !r_entry.valid || (i_new.score > r_entry.score);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.clear) begin
            n_entry.valid = 1'b0;
        end else if (i_ctrl.insert && o_flag) begin
            if (i_left_flag) begin
                n_entry = i_left;
            end else begin
                n_entry       = i_new;
                n_entry.valid = 1'b1;
            end
        end else if (i_ctrl.shift) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

### test/top_n_score_select_test.sv
// ----------------------------------------------------------------------------
// top_n_score_select_test
// self-checking bench for the top-n score selector: score vectors stream in
// with random bursts and gaps, a ranking model predicts the class words and
// a scoreboard compares them as the stalling receiver takes them
// ----------------------------------------------------------------------------
module top_n_score_select_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tns_pkg::*;

    localparam int MaxTop       = MaxTopDef;
    localparam int MaxClasses   = MaxClassesDef;
    localparam int HoldCycles   = 80;
    localparam int IdleLimit    = 4000;
    localparam int SettleCycles = 4;
    localparam int DrainCycles  = 20;
    localparam int RandomItems  = 288;

    typedef enum int {
        MIX_WIDE,
        MIX_TIES,
        MIX_EDGES
    } t_score_mix;

    typedef struct {
        logic [ClassIndexW-1:0]   index;
        logic signed [ScoreW-1:0] score;
        logic                     is_last;
    } t_class_word;

    class ranked_class_model;
        logic [TopCountW-1:0]     top_count;
        logic signed [ScoreW-1:0] kept_score [MaxTop];
        logic [ClassIndexW-1:0]   kept_index [MaxTop];
        int                       filled;
        int                       position;
        int                       errors;
        t_class_word              pending_classes [$];

        function new();
            top_count = TopCountRst;
            filled    = 0;
            position  = 0;
            errors    = 0;
        endfunction

        task report(input string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            errors++;
        endtask

        function void take_score(input logic signed [ScoreW-1:0] s, input logic is_last);
            int          p;
            int          k;
            int          n;
            t_class_word w;
            if (position < MaxClasses) begin
                p = 0;
                while (p < filled && kept_score[p] >= s) p++;
                if (p < MaxTop) begin
                    for (k = (filled < MaxTop) ? filled : MaxTop - 1; k > p; k--) begin
                        kept_score[k] = kept_score[k-1];
                        kept_index[k] = kept_index[k-1];
                    end
                    kept_score[p] = s;
                    kept_index[p] = ClassIndexW'(position);
                    if (filled < MaxTop) filled++;
                end
                position++;
            end
            if (!is_last) return;
            n = (top_count == 0) ? 1 : int'(top_count);
            if (n > MaxTop) n = MaxTop;
            if (n > filled) n = filled;
            for (k = 0; k < n; k++) begin
                w.index   = kept_index[k];
                w.score   = kept_score[k];
                w.is_last = (k == n - 1);
                pending_classes = {pending_classes, w};
            end
            filled   = 0;
            position = 0;
        endfunction

        task check_class(input logic [ClassIndexW-1:0] idx,
                         input logic signed [ScoreW-1:0] sc, input logic is_last);
            t_class_word w;
            if (pending_classes.size() == 0) begin
                report($sformatf("unexpected class word index %0d score %0d", idx, sc));
                return;
            end
            w = pending_classes.pop_front();
            if (idx !== w.index)
                report($sformatf("class_index %0d, expected %0d", idx, w.index));
            if (sc !== w.score)
                report($sformatf("class_score %0d, expected %0d", sc, w.score));
            if (is_last !== w.is_last)
                report($sformatf("last_result %0b, expected %0b", is_last, w.is_last));
        endtask
    endclass

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [AddrW-1:0]    paddr;
    logic [DataW-1:0]    pwdata;
    logic [DataW-1:0]    prdata;
    logic                pready;
    ranked_class_model   ranking;
    bit                  hold_out    = 1'b0;
    int                  burst_left  = 0;
    int                  idle_cycles = 0;

    tns_in_if  u_in ();
    tns_out_if u_out ();

    top_n_score_select u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in),
        .o_out   (u_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (u_out.valid === 1'b1 && u_out.ready === 1'b1)
                ranking.check_class(u_out.class_index, u_out.class_score, u_out.last_result);
            if (u_in.valid === 1'b1 && u_in.ready === 1'b1)
                ranking.take_score(u_in.score, u_in.last_score);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (u_in.valid === 1'b1 && u_in.ready === 1'b1) ||
            (u_out.valid === 1'b1 && u_out.ready === 1'b1) ||
            (psel && penable && pready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IdleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver stall pattern, with one long hold on request
    initial begin
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        u_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_out) begin
                u_out.ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
                hold_out = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (mode)
                0: u_out.ready <= 1'b1;
                1: u_out.ready <= 1'($urandom_range(0, 1));
                default: u_out.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic push_score(input logic signed [ScoreW-1:0] s, input logic is_last);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            if (gap > 0) begin
                u_in.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        u_in.valid      <= 1'b1;
        u_in.score      <= s;
        u_in.last_score <= is_last;
        do @(posedge i_clk); while (u_in.ready !== 1'b1);
    endtask

    task automatic settle();
        u_in.valid <= 1'b0;
        do @(posedge i_clk); while (ranking.pending_classes.size() != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic set_top_count(input int count);
        logic [DataW-1:0]     readback;
        logic [TopCountW-1:0] value;
        value = TopCountW'(count);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TOP_COUNT;
        pwdata  <= {(DataW - TopCountW)'($urandom_range(0, (1 << (DataW - TopCountW)) - 1)),
                    value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        ranking.top_count = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== DataW'(value))
            ranking.report($sformatf("top_count reads %0d, expected %0d", readback, value));
    endtask

    function automatic logic signed [ScoreW-1:0] pick_score(input t_score_mix mix);
        case (mix)
            MIX_TIES: return ScoreW'($signed($urandom_range(0, 3)) - 2) <<< 16;
            MIX_EDGES: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh7FFFFFFF;
                    1: return 32'sh80000000;
                    2: return 32'sh00000000;
                    3: return -32'sd1;
                    default: return 32'sh00000001;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_vector(input int len);
        t_score_mix mix;
        int         k;
        mix = t_score_mix'($urandom_range(0, 2));
        for (k = 0; k < len; k++) push_score(pick_score(mix), k == len - 1);
    endtask

    initial begin
        int fixed_counts [5];
        int sent;
        int phase;
        int phase_items;
        int len;
        fixed_counts = '{1, 15, 8, 0, 3};
        ranking = new();
        u_in.valid      <= 1'b0;
        u_in.score      <= '0;
        u_in.last_score <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_TOP_COUNT;
        pwdata  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset count, extremes and ties
        push_score(32'sh7FFFFFFF, 1'b0);
        push_score(32'sh80000000, 1'b0);
        push_score(32'sh00000000, 1'b0);
        push_score(-32'sd1, 1'b0);
        push_score(32'sh00000000, 1'b0);
        push_score(32'sh00010000, 1'b0);
        push_score(32'sh7FFFFFFF, 1'b1);
        // short vectors
        push_score(32'shFFFF8000, 1'b0);
        push_score(32'sh00008000, 1'b1);
        push_score(32'sh80000000, 1'b1);
        // count of zero reads as one
        set_top_count(0);
        push_score(-32'sd5, 1'b0);
        push_score(32'sd7, 1'b0);
        push_score(32'sd7, 1'b1);
        // count above capacity, more scores than the chain holds, many ties
        set_top_count(15);
        push_score(32'sd3, 1'b0);
        push_score(32'sd1, 1'b0);
        push_score(32'sd3, 1'b0);
        push_score(32'sd2, 1'b0);
        push_score(32'sd3, 1'b0);
        push_score(32'sd3, 1'b0);
        push_score(32'sd1, 1'b0);
        push_score(32'sd3, 1'b0);
        push_score(32'sd3, 1'b0);
        push_score(32'sd3, 1'b1);

        sent  = 0;
        phase = 0;
        while (sent < RandomItems) begin
            set_top_count((phase < 5) ? fixed_counts[phase] : $urandom_range(0, 15));
            if (phase == 1) hold_out = 1'b1;
            phase_items = 0;
            while (phase_items < 40 && sent < RandomItems) begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
                send_vector(len);
                phase_items += len;
                sent        += len;
                if ($urandom_range(0, 7) == 0) settle();
            end
            phase++;
        end

        settle();
        repeat (DrainCycles) @(posedge i_clk);
        if (ranking.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### top_n_score_select.f
src/tns_pkg.sv
src/tns_if.sv
src/tns_cell.sv
src/top_n_score_select.sv
test/top_n_score_select_test.sv
